[rtl/core/sgm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sgm_pkg;

    localparam int unsigned VectorDepthDefault = 4096;

    localparam logic ReqLoad = 1'b0;
    localparam logic ReqMultiply = 1'b1;

    localparam logic [31:0] CanonNan = 32'h7FC0_0000;

    // Operand classification of one single-precision word
    typedef struct packed {
        logic is_zero;
        logic is_inf;
        logic is_nan;
    } fp_class_t;

    function automatic fp_class_t classify(input logic [31:0] w);
        fp_class_t c;
        c.is_zero = (w[30:23] == 8'd0) && (w[22:0] == 23'd0);
        c.is_inf  = (w[30:23] == 8'hFF) && (w[22:0] == 23'd0);
        c.is_nan  = (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
        return c;
    endfunction

    // Number of leading zeros of a 24-bit significand (0..24)
    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd24;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 5'(23 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

[rtl/core/sgm_fmul.sv]
`timescale 1ns / 1ps
`default_nettype none
// Two-stage single-precision multiply: product registered, then rounded
// and registered out; rounds to nearest even, subnormal in and out.
module sgm_fmul (
    input  wire logic        aclk,
    input  wire logic        en_in,
    input  wire logic        en_mid,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] p
);

    // stage 1: decode, normalize subnormal inputs, multiply
    logic [23:0] ma, mb, na, nb;
    logic [4:0]  za, zb;
    logic signed [10:0] ea, eb;
    sgm_pkg::fp_class_t ca, cb;

    always_comb begin
        ca = sgm_pkg::classify(a);
        cb = sgm_pkg::classify(b);
        ma = {(a[30:23] != 8'd0), a[22:0]};
        mb = {(b[30:23] != 8'd0), b[22:0]};
        za = sgm_pkg::lzc24(ma);
        zb = sgm_pkg::lzc24(mb);
        na = ma << za;
        nb = mb << zb;
        ea = 11'(signed'({3'd0, a[30:23]})) + ((a[30:23] == 8'd0) ? 11'sd1 : 11'sd0)
             - 11'(signed'({6'd0, za}));
        eb = 11'(signed'({3'd0, b[30:23]})) + ((b[30:23] == 8'd0) ? 11'sd1 : 11'sd0)
             - 11'(signed'({6'd0, zb}));
    end

    logic [47:0]        prod_reg;
    logic signed [10:0] exp_reg;
    logic               sign_reg, nan_reg, inf_reg, zero_reg;

    always_ff @(posedge aclk) begin
        if (en_in) begin
            prod_reg <= na * nb;
            exp_reg  <= ea + eb - 11'sd127;
            sign_reg <= a[31] ^ b[31];
            nan_reg  <= ca.is_nan || cb.is_nan || (ca.is_inf && cb.is_zero)
                        || (ca.is_zero && cb.is_inf);
            inf_reg  <= ca.is_inf || cb.is_inf;
            zero_reg <= ca.is_zero || cb.is_zero;
        end
    end

    // stage 2: normalize, shift into subnormal range, round
    logic [47:0]        pn;
    logic signed [10:0] e;
    logic [8:0]         rsh;
    logic [49:0]        sh;
    logic [23:0]        keep;
    logic               gbit, sticky, rinc;
    logic [24:0]        rnd;
    logic signed [10:0] ef;
    logic [31:0]        res;

    always_comb begin
        if (prod_reg[47]) begin
            pn = prod_reg;
            e  = exp_reg + 11'sd1;
        end else begin
            pn = prod_reg << 1;
            e  = exp_reg;
        end
        // pn[47] is the leading one; value = pn/2^47 * 2^(e-127)
        if (e < 11'sd1) begin
            rsh = (e < -11'sd30) ? 9'd31 : 9'(11'sd1 - e);
        end else begin
            rsh = 9'd0;
        end
        sh     = {pn, 2'b00} >> rsh;
        keep   = sh[49:26];
        gbit   = sh[25];
        sticky = (sh[24:0] != 25'd0) || ((({pn, 2'b00} << (9'd50 - rsh)) != 50'd0)
                 && (rsh != 9'd0));
        rinc   = gbit && (sticky || keep[0]);
        rnd    = {1'b0, keep} + {24'd0, rinc};
        ef     = (rsh != 9'd0) ? 11'sd0 : e;
        if (rnd[24]) begin
            ef  = ef + 11'sd1;
            rnd = rnd >> 1;
        end else if (rsh != 9'd0 && rnd[23]) begin
            ef = 11'sd1;
        end
        if (nan_reg) begin
            res = sgm_pkg::CanonNan;
        end else if (inf_reg) begin
            res = {sign_reg, 8'hFF, 23'd0};
        end else if (zero_reg) begin
            res = {sign_reg, 31'd0};
        end else if (ef >= 11'sd255) begin
            res = {sign_reg, 8'hFF, 23'd0};
        end else begin
            res = {sign_reg, ef[7:0], rnd[22:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en_mid) begin
            p <= res;
        end
    end

endmodule
`default_nettype wire

[rtl/core/sparse_gather_multiply.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Ports                                   | Dir
// request  | s_valid s_ready s_req_type s_index s_value_bits | in
// product  | m_valid m_ready m_product_bits          | out
//
// One request per cycle is taken while the pipe advances. A multiply
// passes three register stages: vector store read, multiply, then round
// into the output register, so m_valid rises once the request has moved
// through v1_reg and v2_reg into v3_reg. Loads write the store and give
// no product. The store has no reset; only control valids clear on
// aresetn. The whole pipe advances only when the output register is
// empty or being drained; a stall holds every stage.
module sparse_gather_multiply #(
    parameter int unsigned VECTOR_DEPTH = sgm_pkg::VectorDepthDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [11:0] s_index,
    input  wire logic [31:0] s_value_bits,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_product_bits
);

    localparam int unsigned AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

    logic [31:0] vec_mem [VECTOR_DEPTH];

    logic        advance;
    logic        s_fire;
    logic        in_range;
    logic [AW-1:0] addr;

    logic        v1_reg, v2_reg, v3_reg;
    logic        oob_reg;
    logic [31:0] val_reg, elem_reg;

    // advance the pipe unless the output holds an untaken product
    assign advance = !v3_reg || m_ready;
    assign s_ready = advance;
    assign s_fire  = s_valid && s_ready;
    assign in_range = (32'(s_index) < 32'(VECTOR_DEPTH));
    assign addr    = AW'(s_index);

    // store: write on load, registered read on every accepted request
    always_ff @(posedge aclk) begin
        if (s_fire && s_req_type == sgm_pkg::ReqLoad && in_range) begin
            vec_mem[addr] <= s_value_bits;
        end
        if (s_fire) begin
            elem_reg <= vec_mem[addr];
            val_reg  <= s_value_bits;
            oob_reg  <= !in_range;
        end
    end

    logic v1_next;
    assign v1_next = s_fire && (s_req_type == sgm_pkg::ReqMultiply);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= v1_next;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // drop element to +0 when the column lies beyond the store
    sgm_fmul u_fmul (
        .aclk   (aclk),
        .en_in  (advance),
        .en_mid (advance),
        .a      (val_reg),
        .b      (oob_reg ? 32'd0 : elem_reg),
        .p      (m_product_bits)
    );

    assign m_valid = v3_reg;

    // stalled product must hold
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_product_bits))
        else $error("product changed under stall");

    // no intake while output is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("request taken under stall");

    // a load never yields a product
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_req_type == sgm_pkg::ReqLoad |=> !v1_reg)
        else $error("load produced work");

endmodule
`default_nettype wire
